// ===== hw/rtl/mhpq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mhpq_pkg
// Shared constants, types and helpers of the max-heap priority queue.
// ----------------------------------------------------------------------------
package mhpq_pkg;

   localparam int CAPACITY = 1023;
   localparam int KEY_W    = 31;
   localparam int OCC_W    = 10;
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int LEVELS   = CNT_W;
   localparam int POS_W    = LEVELS - 1;
   localparam int ROW_W    = (POS_W > 1) ? POS_W - 1 : 1;
   localparam int LVL_W    = $clog2(LEVELS);
   localparam int IDX_W    = CNT_W + 1;

   typedef enum logic [0:0] {
      OP_INSERT = 1'b0,
      OP_DELETE = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FETCH,
      ST_RUN
   } state_type;

   typedef logic [1:0][KEY_W-1:0] pair_type;

   // item travelling down the chain of levels
   typedef struct packed {
      logic             valid;
      op_type           op;
      logic [KEY_W-1:0] val;
      logic [POS_W-1:0] pos;
      logic [CNT_W-1:0] cnt;
      logic [LVL_W-1:0] depth;
   } tok_type;

   // write into the level above
   typedef struct packed {
      logic             valid;
      logic [POS_W-1:0] pos;
      logic [KEY_W-1:0] val;
   } bw_type;

   typedef struct packed {
      logic             valid;
      logic [LVL_W-1:0] level;
      logic [POS_W-1:0] pos;
   } fetch_type;

   typedef struct packed {
      logic             valid;
      logic [KEY_W-1:0] data;
   } fetch_rsp_type;

   function automatic logic [LVL_W-1:0] msb_index(input logic [CNT_W-1:0] v);
      logic [LVL_W-1:0] r;
      r = '0;
      for (int i = 0; i < CNT_W; i++) begin
         if (v[i]) begin
            r = LVL_W'(i);
         end
      end
      return r;
   endfunction

endpackage

// ===== hw/rtl/mhpq_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mhpq_ram
// Row memory of one heap level: two sibling keys per row, write per half.
// ----------------------------------------------------------------------------
module mhpq_ram #(
   parameter int AW = 1
) (
   input  logic                      clock,
   input  logic [AW-1:0]             rd_addr,
   output mhpq_pkg::pair_type        rd_data,
   input  logic [1:0]                wr_en,
   input  logic [AW-1:0]             wr_addr,
   input  logic [mhpq_pkg::KEY_W-1:0] wr_data
);
   import mhpq_pkg::*;

   pair_type mem [2**AW];
   pair_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en[0]) begin
         mem[wr_addr][0] <= wr_data;
      end
      if (wr_en[1]) begin
         mem[wr_addr][1] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/mhpq_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mhpq_cell
// One heap level: reads its row, compares, writes back and hands the item on.
// ----------------------------------------------------------------------------
module mhpq_cell (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [mhpq_pkg::LVL_W-1:0]    level_id,
   input  mhpq_pkg::tok_type             tok_in,
   output mhpq_pkg::tok_type             tok_out,
   input  mhpq_pkg::bw_type              bw_in,
   output mhpq_pkg::bw_type              bw_out,
   input  mhpq_pkg::fetch_type           fetch_in,
   output mhpq_pkg::fetch_rsp_type       fetch_out,
   output logic                          done,
   output logic [mhpq_pkg::ROW_W-1:0]    ram_rd_addr,
   input  mhpq_pkg::pair_type            ram_rd_data,
   output logic [1:0]                    ram_wr_en,
   output logic [mhpq_pkg::ROW_W-1:0]    ram_wr_addr,
   output logic [mhpq_pkg::KEY_W-1:0]    ram_wr_data
);
   import mhpq_pkg::*;

   tok_type          tok_ff;
   logic             fhit_ff;
   logic             fhalf_ff;

   logic             is_last;
   logic [KEY_W-1:0] cur;
   logic             at_tgt;
   logic             swap;
   logic [LVL_W-1:0] bitsel;
   logic             nxt_bit;
   logic [IDX_W-1:0] base;
   logic [IDX_W-1:0] idx_l;
   logic [IDX_W-1:0] idx_r;
   logic             lv;
   logic             rv;
   logic             sel;
   logic [KEY_W-1:0] pv;
   logic             go;
   logic             own_we;
   logic             own_half;
   logic [ROW_W-1:0] own_row;
   logic [KEY_W-1:0] own_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff  <= '0;
         fhit_ff <= 1'b0;
      end else begin
         tok_ff  <= tok_in;
         fhit_ff <= fetch_in.valid && (fetch_in.level == level_id);
      end
      fhalf_ff <= fetch_in.pos[0];
   end

   always_comb begin
      if (tok_in.valid) begin
         ram_rd_addr = (tok_in.op == OP_INSERT) ? ROW_W'(tok_in.pos >> 1)
                                                : ROW_W'(tok_in.pos);
      end else begin
         ram_rd_addr = ROW_W'(fetch_in.pos >> 1);
      end
   end

   assign fetch_out.valid = fhit_ff;
   assign fetch_out.data  = fhit_ff ? (fhalf_ff ? ram_rd_data[1] : ram_rd_data[0]) : '0;

   assign is_last = (level_id == LVL_W'(LEVELS - 1));

   // insert path: walk toward the new slot, keep the larger key here
   assign cur     = tok_ff.pos[0] ? ram_rd_data[1] : ram_rd_data[0];
   assign at_tgt  = (tok_ff.depth == level_id);
   assign swap    = tok_ff.val > cur;
   assign bitsel  = tok_ff.depth - level_id - LVL_W'(1);
   assign nxt_bit = tok_ff.cnt[bitsel];

   // delete path: children of the hole sit in row pos of this level
   assign base  = (IDX_W'(1) << level_id) - IDX_W'(1);
   assign idx_l = base + IDX_W'({tok_ff.pos, 1'b0});
   assign idx_r = idx_l + IDX_W'(1);
   assign lv    = idx_l < IDX_W'(tok_ff.cnt);
   assign rv    = idx_r < IDX_W'(tok_ff.cnt);
   assign sel   = rv && (ram_rd_data[1] >= ram_rd_data[0]);
   assign pv    = sel ? ram_rd_data[1] : ram_rd_data[0];
   assign go    = lv && (tok_ff.val < pv);

   always_comb begin
      tok_out  = tok_ff;
      tok_out.valid = 1'b0;
      bw_out   = '0;
      done     = 1'b0;
      own_we   = 1'b0;
      own_half = tok_ff.pos[0];
      own_row  = ROW_W'(tok_ff.pos >> 1);
      own_data = tok_ff.val;
      if (tok_ff.valid) begin
         unique case (tok_ff.op)
            OP_INSERT: begin
               if (at_tgt) begin
                  own_we = 1'b1;
                  done   = 1'b1;
               end else begin
                  own_we        = swap;
                  tok_out.valid = 1'b1;
                  tok_out.val   = swap ? cur : tok_ff.val;
                  tok_out.pos   = POS_W'({tok_ff.pos, nxt_bit});
               end
            end
            OP_DELETE: begin
               bw_out.valid = 1'b1;
               bw_out.pos   = tok_ff.pos;
               bw_out.val   = go ? pv : tok_ff.val;
               if (!go) begin
                  done = 1'b1;
               end else if (is_last) begin
                  own_we   = 1'b1;
                  own_half = sel;
                  own_row  = ROW_W'(tok_ff.pos);
                  done     = 1'b1;
               end else begin
                  tok_out.valid = 1'b1;
                  tok_out.pos   = POS_W'({tok_ff.pos, sel});
               end
            end
            default: ;
         endcase
      end
   end

   // the level below writes back only after this level is done with the item
   always_comb begin
      if (bw_in.valid) begin
         ram_wr_en   = bw_in.pos[0] ? 2'b10 : 2'b01;
         ram_wr_addr = ROW_W'(bw_in.pos >> 1);
         ram_wr_data = bw_in.val;
      end else begin
         ram_wr_en   = own_we ? (own_half ? 2'b10 : 2'b01) : 2'b00;
         ram_wr_addr = own_row;
         ram_wr_data = own_data;
      end
   end

endmodule

// ===== hw/rtl/mhpq_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mhpq_ctrl
// Command sequencer: holds root and count, launches items into the level chain.
// ----------------------------------------------------------------------------
module mhpq_ctrl (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic                              req_kind,
   input  logic [mhpq_pkg::KEY_W-1:0]        req_key,
   output logic                              rsp_valid,
   output logic                              rsp_ok,
   output logic [mhpq_pkg::KEY_W-1:0]        rsp_removed_key,
   output logic [mhpq_pkg::OCC_W-1:0]        rsp_occupancy,
   output mhpq_pkg::tok_type                 tok_out,
   input  mhpq_pkg::bw_type                  bw_in,
   output mhpq_pkg::fetch_type               fetch_out,
   input  mhpq_pkg::fetch_rsp_type           fetch_rsp,
   input  logic                              done
);
   import mhpq_pkg::*;

   state_type        state_ff;
   state_type        state_in;
   logic [CNT_W-1:0] cnt_ff;
   logic [KEY_W-1:0] root_ff;
   tok_type          tok_ff;
   fetch_type        fetch_ff;
   logic             rsp_valid_ff;
   logic             rsp_ok_ff;
   logic [KEY_W-1:0] removed_ff;

   logic             accept;
   logic             is_del;
   logic [CNT_W-1:0] cnt_inc;
   logic [LVL_W-1:0] ins_depth;
   logic [LVL_W-1:0] del_depth;
   logic [CNT_W-1:0] del_pos;

   assign accept    = start && !busy;
   assign is_del    = (op_type'(req_kind) == OP_DELETE);
   assign cnt_inc   = cnt_ff + CNT_W'(1);
   assign ins_depth = msb_index(cnt_inc);
   assign del_depth = msb_index(cnt_ff);
   assign del_pos   = cnt_ff & ~(CNT_W'(1) << del_depth);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (is_del && cnt_ff > CNT_W'(1)) begin
                  state_in = ST_FETCH;
               end else if (!is_del && cnt_ff != CNT_W'(0)
                            && cnt_ff != CNT_W'(CAPACITY)) begin
                  state_in = ST_RUN;
               end
            end
         end
         ST_FETCH: begin
            if (fetch_rsp.valid) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (done) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      busy = (state_ff != ST_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         tok_ff       <= '0;
         fetch_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff       <= state_in;
         rsp_valid_ff   <= 1'b0;
         tok_ff.valid   <= 1'b0;
         fetch_ff.valid <= 1'b0;
         if (bw_in.valid) begin
            root_ff <= bw_in.val;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  removed_ff <= '0;
                  rsp_ok_ff  <= 1'b0;
                  if (is_del) begin
                     if (cnt_ff == CNT_W'(1)) begin
                        removed_ff   <= root_ff;
                        rsp_ok_ff    <= 1'b1;
                        cnt_ff       <= '0;
                        rsp_valid_ff <= 1'b1;
                     end else if (cnt_ff == CNT_W'(0)) begin
                        rsp_valid_ff <= 1'b1;
                     end else begin
                        removed_ff     <= root_ff;
                        cnt_ff         <= cnt_ff - CNT_W'(1);
                        fetch_ff.valid <= 1'b1;
                        fetch_ff.level <= del_depth;
                        fetch_ff.pos   <= POS_W'(del_pos);
                     end
                  end else begin
                     if (cnt_ff == CNT_W'(CAPACITY)) begin
                        rsp_valid_ff <= 1'b1;
                     end else if (cnt_ff == CNT_W'(0)) begin
                        root_ff      <= req_key;
                        cnt_ff       <= CNT_W'(1);
                        rsp_ok_ff    <= 1'b1;
                        rsp_valid_ff <= 1'b1;
                     end else begin
                        // keep the larger key at the root, carry the other down
                        if (req_key > root_ff) begin
                           root_ff    <= req_key;
                           tok_ff.val <= root_ff;
                        end else begin
                           tok_ff.val <= req_key;
                        end
                        tok_ff.valid <= 1'b1;
                        tok_ff.op    <= OP_INSERT;
                        tok_ff.pos   <= POS_W'(cnt_inc[ins_depth - LVL_W'(1)]);
                        tok_ff.cnt   <= cnt_inc;
                        tok_ff.depth <= ins_depth;
                        cnt_ff       <= cnt_inc;
                     end
                  end
               end
            end
            ST_FETCH: begin
               if (fetch_rsp.valid) begin
                  tok_ff.valid <= 1'b1;
                  tok_ff.op    <= OP_DELETE;
                  tok_ff.val   <= fetch_rsp.data;
                  tok_ff.pos   <= '0;
                  tok_ff.cnt   <= cnt_ff;
                  tok_ff.depth <= '0;
               end
            end
            ST_RUN: begin
               if (done) begin
                  rsp_ok_ff    <= 1'b1;
                  rsp_valid_ff <= 1'b1;
               end
            end
            default: ;
         endcase
      end
   end

   assign tok_out         = tok_ff;
   assign fetch_out       = fetch_ff;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_ok          = rsp_ok_ff;
   assign rsp_removed_key = removed_ff;
   assign rsp_occupancy   = OCC_W'(cnt_ff);

   a_done_in_run : assert property (@(posedge clock) disable iff (reset)
      done |-> state_ff == ST_RUN)
      else $error("level chain finished outside of run state");

   a_fetch_in_fetch : assert property (@(posedge clock) disable iff (reset)
      fetch_rsp.valid |-> state_ff == ST_FETCH)
      else $error("last-entry fetch returned outside of fetch state");

   a_refuse_keeps_count : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ok_ff) |-> cnt_ff == $past(cnt_ff))
      else $error("refused item changed the count");

   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(CAPACITY))
      else $error("count above capacity");

endmodule

// ===== hw/rtl/max_heap_priority_queue_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// max_heap_priority_queue_unit
// Binary max-heap priority queue built as a chain of per-level cells.
// ----------------------------------------------------------------------------
// Usage:
//   Raise start with req_kind (0 insert req_key, 1 delete maximum) while busy
//   is low; the item is taken at that clock edge. Exactly one result follows
//   on rsp_ok / rsp_removed_key / rsp_occupancy, marked by a one-cycle
//   rsp_valid strobe; the receiver cannot stall it.
// Operation:
//   The root and the count live in the sequencer; every deeper heap level is
//   one cell with its own row memory, and an item passes the cells in order:
//   the registered row read of a level overlaps the compare and write of the
//   level above. An insert stops at the level of its new slot; a delete first
//   fetches the last entry and then sifts down.
//   Refused items, deletes on a heap of at most one key and inserts into an
//   empty heap are answered by the sequencer in the cycle after they are
//   taken. One item is in the chain at a time; busy is low again in the cycle
//   the result is shown.
// Reset:
//   Synchronous reset empties the queue; memory contents are not cleared.
// ----------------------------------------------------------------------------
module max_heap_priority_queue_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_kind,
   input  logic [mhpq_pkg::KEY_W-1:0]    req_key,
   output logic                          rsp_valid,
   output logic                          rsp_ok,
   output logic [mhpq_pkg::KEY_W-1:0]    rsp_removed_key,
   output logic [mhpq_pkg::OCC_W-1:0]    rsp_occupancy
);
   import mhpq_pkg::*;

   tok_type       tok_chain [0:LEVELS-1];
   bw_type        bw_chain  [1:LEVELS-1];
   fetch_rsp_type fetch_cell [1:LEVELS-1];
   logic          done_vec  [1:LEVELS-1];
   fetch_type     fetch_req;
   fetch_rsp_type fetch_rsp;
   logic          done_any;

   always_comb begin
      fetch_rsp = '0;
      done_any  = 1'b0;
      for (int k = 1; k < LEVELS; k++) begin
         fetch_rsp.valid = fetch_rsp.valid | fetch_cell[k].valid;
         fetch_rsp.data  = fetch_rsp.data  | fetch_cell[k].data;
         done_any        = done_any | done_vec[k];
      end
   end

   mhpq_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_kind        (req_kind),
      .req_key         (req_key),
      .rsp_valid       (rsp_valid),
      .rsp_ok          (rsp_ok),
      .rsp_removed_key (rsp_removed_key),
      .rsp_occupancy   (rsp_occupancy),
      .tok_out         (tok_chain[0]),
      .bw_in           (bw_chain[1]),
      .fetch_out       (fetch_req),
      .fetch_rsp       (fetch_rsp),
      .done            (done_any)
   );

   for (genvar k = 1; k < LEVELS; k++) begin : g_level
      localparam int AW = (k > 1) ? k - 1 : 1;

      logic [ROW_W-1:0] rd_addr;
      pair_type         rd_data;
      logic [1:0]       wr_en;
      logic [ROW_W-1:0] wr_addr;
      logic [KEY_W-1:0] wr_data;
      bw_type           bw_below;

      if (k == LEVELS - 1) begin : g_last
         assign bw_below = '0;
      end else begin : g_mid
         assign bw_below = bw_chain[k+1];
      end

      mhpq_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .level_id    (LVL_W'(k)),
         .tok_in      (tok_chain[k-1]),
         .tok_out     (tok_chain[k]),
         .bw_in       (bw_below),
         .bw_out      (bw_chain[k]),
         .fetch_in    (fetch_req),
         .fetch_out   (fetch_cell[k]),
         .done        (done_vec[k]),
         .ram_rd_addr (rd_addr),
         .ram_rd_data (rd_data),
         .ram_wr_en   (wr_en),
         .ram_wr_addr (wr_addr),
         .ram_wr_data (wr_data)
      );

      mhpq_ram #(
         .AW (AW)
      ) u_ram (
         .clock   (clock),
         .rd_addr (rd_addr[AW-1:0]),
         .rd_data (rd_data),
         .wr_en   (wr_en),
         .wr_addr (wr_addr[AW-1:0]),
         .wr_data (wr_data)
      );
   end

endmodule
